// ===== rtl/ows_pkg.sv =====
package ows_pkg;

    // fixed field widths
    localparam int MODE_W      = 3;
    localparam int SEL_W       = 2;
    localparam int DATA_W      = 8;
    localparam int UNIT_W      = 16;
    localparam int UCNT_W      = 6;
    localparam int BCNT_W      = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int QUEUE_DEPTH = 2;

    // command codes on the mode field
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESET      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE_BYTE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_BYTE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE_BIT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_BIT   = 3'd5;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_UNIT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_UNIT  = 4'd1;

    localparam logic [UNIT_W-1:0] SHORT_UNIT_RESET = 16'd201;
    localparam logic [UNIT_W-1:0] LONG_UNIT_RESET  = 16'd2001;

    // segment lengths in units
    localparam logic [UCNT_W-1:0] RST_LOW_UNITS   = 6'd42;
    localparam logic [UCNT_W-1:0] RST_PRES_UNITS  = 6'd6;
    localparam logic [UCNT_W-1:0] RST_TAIL_UNITS  = 6'd22;
    localparam logic [UCNT_W-1:0] WR_LEAD_UNITS   = 6'd3;
    localparam logic [UCNT_W-1:0] WR_MID_UNITS    = 6'd7;
    localparam logic [UCNT_W-1:0] WR_TAIL_UNITS   = 6'd2;
    localparam logic [UCNT_W-1:0] RD_LOW_UNITS    = 6'd1;
    localparam logic [UCNT_W-1:0] RD_SAMPLE_UNITS = 6'd1;
    localparam logic [UCNT_W-1:0] RD_TAIL_UNITS   = 6'd6;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_RESET,
        CMD_WRITE_BYTE,
        CMD_READ_BYTE,
        CMD_WRITE_BIT,
        CMD_READ_BIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [UNIT_W-1:0] short_ticks;
        logic [UNIT_W-1:0] long_ticks;
    } unit_cfg_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_R1,
        PH_R2,
        PH_R3,
        PH_W1,
        PH_W2,
        PH_W3,
        PH_D1,
        PH_D2,
        PH_D3
    } phase_t;

    function automatic logic [UCNT_W-1:0] seg_units(phase_t ph);
        logic [UCNT_W-1:0] u;
        case (ph)
            PH_R1:   u = RST_LOW_UNITS;
            PH_R2:   u = RST_PRES_UNITS;
            PH_R3:   u = RST_TAIL_UNITS;
            PH_W1:   u = WR_LEAD_UNITS;
            PH_W2:   u = WR_MID_UNITS;
            PH_W3:   u = WR_TAIL_UNITS;
            PH_D1:   u = RD_LOW_UNITS;
            PH_D2:   u = RD_SAMPLE_UNITS;
            PH_D3:   u = RD_TAIL_UNITS;
            default: u = '0;
        endcase
        return u;
    endfunction

    function automatic logic seg_is_long(phase_t ph);
        logic l;
        case (ph) inside
            PH_R1, PH_R2, PH_R3, PH_W2, PH_D2, PH_D3: l = 1'b1;
            default:                                  l = 1'b0;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/ows_front.sv =====
module ows_front #(
    parameter int NUM_LINES = 3,
    parameter int LW        = 2
) (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ows_pkg::MODE_W-1:0]  s_mode,
    input  logic [ows_pkg::SEL_W-1:0]   s_line_select,
    input  logic [ows_pkg::DATA_W-1:0]  s_write_data,
    input  logic                        q_full,
    output logic                        q_push,
    output ows_pkg::cmd_t               q_cmd,
    output logic [LW-1:0]               q_line
);
    import ows_pkg::*;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // decode mode, undefined codes become a plain tick
    always_comb begin
        q_cmd.kind = CMD_NONE;
        q_cmd.data = s_write_data;
        unique case (s_mode)
            MODE_TICK:       q_cmd.kind = CMD_NONE;
            MODE_RESET:      q_cmd.kind = CMD_RESET;
            MODE_WRITE_BYTE: q_cmd.kind = CMD_WRITE_BYTE;
            MODE_READ_BYTE:  q_cmd.kind = CMD_READ_BYTE;
            MODE_WRITE_BIT: begin
                q_cmd.kind = CMD_WRITE_BIT;
                q_cmd.data = {{(DATA_W-1){1'b0}}, s_write_data[0]};
            end
            MODE_READ_BIT:   q_cmd.kind = CMD_READ_BIT;
            default:         q_cmd.kind = CMD_NONE;
        endcase
    end

    // out-of-range line falls back to the last line
    always_comb begin
        if (int'(s_line_select) < NUM_LINES) begin
            q_line = LW'(s_line_select);
        end else begin
            q_line = LW'(NUM_LINES - 1);
        end
    end

endmodule

// ===== rtl/ows_fifo.sv =====
module ows_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count above depth");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drain the queue");

endmodule

// ===== rtl/ows_back.sv =====
module ows_back #(
    parameter int NUM_LINES  = 3,
    parameter int TICK_WIDTH = 16,
    parameter int LW         = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ows_pkg::unit_cfg_t          unit_cfg,
    input  logic                        q_valid,
    input  ows_pkg::cmd_t               q_cmd,
    input  logic [LW-1:0]               q_line,
    input  logic [NUM_LINES-1:0]        q_levels,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [NUM_LINES-1:0]        m_drive_low,
    output logic                        m_busy_res,
    output logic                        m_done_res,
    output logic [ows_pkg::DATA_W-1:0]  m_read_data,
    output logic                        m_presence,
    output logic                        m_released_high
);
    import ows_pkg::*;

    localparam int CW = (TICK_WIDTH + 1 > UNIT_W + 1) ? TICK_WIDTH + 1 : UNIT_W + 1;

    phase_t                phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [UCNT_W-1:0]     unit_count_reg, unit_count_next;
    logic [BCNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [DATA_W-1:0]     shift_reg, shift_next;
    logic [LW-1:0]         active_line_reg, active_line_next;
    logic                  single_bit_reg, single_bit_next;
    logic                  presence_reg, presence_next;
    logic                  high_reg, high_next;

    logic                  m_valid_reg, m_valid_next;
    logic [NUM_LINES-1:0]  m_drive_low_reg, drive_vec;
    logic                  m_busy_reg, m_done_reg, done_next;
    logic [DATA_W-1:0]     m_read_data_reg, rd_next;
    logic                  m_presence_reg, m_high_reg;

    logic                  level;
    logic [UNIT_W-1:0]     ticks;
    logic [TICK_WIDTH:0]   tick_inc;
    logic                  seg_end;
    logic [UCNT_W-1:0]     unit_inc;
    logic                  last_bit;
    logic                  drive;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        unit_count_next  = unit_count_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        active_line_next = active_line_reg;
        single_bit_next  = single_bit_reg;
        presence_next    = presence_reg;
        high_next        = high_reg;
        done_next        = 1'b0;
        rd_next          = '0;

        level    = q_levels[active_line_reg];
        ticks    = seg_is_long(phase_reg) ? unit_cfg.long_ticks : unit_cfg.short_ticks;
        tick_inc = {1'b0, tick_count_reg} + {{TICK_WIDTH{1'b0}}, 1'b1};
        seg_end  = (CW'(tick_inc) >= CW'(ticks)) || tick_inc[TICK_WIDTH];
        unit_inc = unit_count_reg + 1'b1;
        last_bit = single_bit_reg || (bit_count_reg == BCNT_W'(DATA_W - 1));

        if (q_pop) begin
            if (phase_reg == PH_IDLE) begin
                if (q_cmd.kind != CMD_NONE) begin
                    active_line_next = q_line;
                    tick_count_next  = '0;
                    unit_count_next  = '0;
                    bit_count_next   = '0;
                    single_bit_next  = (q_cmd.kind == CMD_WRITE_BIT) ||
                                       (q_cmd.kind == CMD_READ_BIT);
                end
                unique case (q_cmd.kind)
                    CMD_RESET: phase_next = PH_R1;
                    CMD_WRITE_BYTE, CMD_WRITE_BIT: begin
                        shift_next = q_cmd.data;
                        phase_next = PH_W1;
                    end
                    CMD_READ_BYTE, CMD_READ_BIT: begin
                        shift_next = '0;
                        phase_next = PH_D1;
                    end
                    default: ;
                endcase
            end else if (seg_end) begin
                tick_count_next = '0;
                unit_count_next = unit_inc;
                if (unit_inc >= seg_units(phase_reg)) begin
                    unit_count_next = '0;
                    unique case (phase_reg)
                        PH_R1: phase_next = PH_R2;
                        PH_R2: begin
                            presence_next = !level;
                            phase_next    = PH_R3;
                        end
                        PH_R3: begin
                            high_next  = level;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        PH_W1: phase_next = PH_W2;
                        PH_W2: phase_next = PH_W3;
                        PH_W3: begin
                            bit_count_next = bit_count_reg + 1'b1;
                            if (last_bit) begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end else begin
                                shift_next = {1'b0, shift_reg[DATA_W-1:1]};
                                phase_next = PH_W1;
                            end
                        end
                        PH_D1: phase_next = PH_D2;
                        PH_D2: begin
                            if (single_bit_reg) begin
                                shift_next = {{(DATA_W-1){1'b0}}, level};
                            end else begin
                                shift_next = {level, shift_reg[DATA_W-1:1]};
                            end
                            phase_next = PH_D3;
                        end
                        PH_D3: begin
                            bit_count_next = bit_count_reg + 1'b1;
                            if (last_bit) begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                                rd_next    = shift_reg;
                            end else begin
                                phase_next = PH_D1;
                            end
                        end
                        default: ;
                    endcase
                end
            end else begin
                tick_count_next = tick_inc[TICK_WIDTH-1:0];
            end
        end

        // drive follows the updated state
        case (phase_next) inside
            PH_R1, PH_W1, PH_D1: drive = 1'b1;
            PH_W2:               drive = !shift_next[0];
            default:             drive = 1'b0;
        endcase
        drive_vec = drive ? (NUM_LINES'(1) << active_line_next) : '0;

        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            unit_count_reg  <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            active_line_reg <= '0;
            single_bit_reg  <= 1'b0;
            presence_reg    <= 1'b0;
            high_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            unit_count_reg  <= unit_count_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            active_line_reg <= active_line_next;
            single_bit_reg  <= single_bit_next;
            presence_reg    <= presence_next;
            high_reg        <= high_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_drive_low_reg <= drive_vec;
            m_busy_reg      <= (phase_next != PH_IDLE);
            m_done_reg      <= done_next;
            m_read_data_reg <= rd_next;
            m_presence_reg  <= presence_next;
            m_high_reg      <= high_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_low     = m_drive_low_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_done_res      = m_done_reg;
    assign m_read_data     = m_read_data_reg;
    assign m_presence      = m_presence_reg;
    assign m_released_high = m_high_reg;

    a_idle_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> (tick_count_reg == '0 && unit_count_reg == '0))
        else $error("counters not cleared in idle");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && phase_reg == PH_IDLE && q_cmd.kind != CMD_NONE)
            |=> (phase_reg != PH_IDLE && m_busy_reg))
        else $error("command did not start");

    a_read_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_done_reg) |-> m_read_data_reg == '0)
        else $error("read data outside done tick");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> unit_count_reg < seg_units(phase_reg))
        else $error("unit count beyond segment length");

endmodule

// ===== rtl/onewire_master_sequencer_unit.sv =====
// open-drain bus master for up to four lines, driven by one input transfer per
// timing tick. each s_ transfer is one tick of the time base and yields exactly
// one m_ transfer with the line drive and status for that tick. when idle, a
// transfer with mode 1 to 5 starts a command (bus reset with presence detect,
// write byte, read byte, write bit, read bit) on the selected line; commands
// that arrive while busy are ignored and treated as plain ticks. bytes go lsb
// first. segment timing is counted in short and long units whose lengths in
// ticks come from the two configuration registers (index 0 short, index 1
// long), which must only be written while no command is running. rate: one
// tick per clock cycle sustained while the m_ side keeps accepting; the
// sequencer updates its full state on every tick. an s_ transfer reaches its
// m_ transfer through the command queue, then the output register. a stalled
// m_ side fills the two-entry queue before s_ready drops.
module onewire_master_sequencer_unit #(
    parameter int NUM_LINES  = 3,
    parameter int TICK_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ows_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ows_pkg::UNIT_W-1:0]       cfg_data,

    // tick / command input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ows_pkg::MODE_W-1:0]       s_mode,
    input  logic [ows_pkg::SEL_W-1:0]        s_line_select,
    input  logic [ows_pkg::DATA_W-1:0]       s_write_data,
    input  logic [NUM_LINES-1:0]             s_line_levels,

    // per-tick result
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [NUM_LINES-1:0]             m_drive_low,
    output logic                             m_busy_res,
    output logic                             m_done_res,
    output logic [ows_pkg::DATA_W-1:0]       m_read_data,
    output logic                             m_presence,
    output logic                             m_released_high
);
    import ows_pkg::*;

    localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int QW = $bits(cmd_t) + LW + NUM_LINES;

    // unit length registers
    unit_cfg_t unit_cfg_reg, unit_cfg_next;

    // front to queue
    logic          q_full;
    logic          q_push;
    cmd_t          f_cmd;
    logic [LW-1:0] f_line;

    // queue to back
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_rd_data;
    cmd_t             b_cmd;
    logic [LW-1:0]    b_line;
    logic [NUM_LINES-1:0] b_levels;

    // config writes are always accepted (cfg_ready tied high), unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        unit_cfg_next = unit_cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHORT_UNIT: unit_cfg_next.short_ticks = cfg_data;
                REG_LONG_UNIT:  unit_cfg_next.long_ticks  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_cfg_reg.short_ticks <= SHORT_UNIT_RESET;
            unit_cfg_reg.long_ticks  <= LONG_UNIT_RESET;
        end else begin
            unit_cfg_reg <= unit_cfg_next;
        end
    end

    // front: takes transfers, decodes mode and clamps the line select
    ows_front #(
        .NUM_LINES (NUM_LINES),
        .LW        (LW)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_line_select (s_line_select),
        .s_write_data  (s_write_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (f_cmd),
        .q_line        (f_line)
    );

    // short queue decouples intake from the sequencer and output stall
    ows_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_cmd, f_line, s_line_levels}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .not_empty (q_valid)
    );

    assign {b_cmd, b_line, b_levels} = q_rd_data;

    // back: bus timing sequencer with registered result
    ows_back #(
        .NUM_LINES  (NUM_LINES),
        .TICK_WIDTH (TICK_WIDTH),
        .LW         (LW)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .unit_cfg        (unit_cfg_reg),
        .q_valid         (q_valid),
        .q_cmd           (b_cmd),
        .q_line          (b_line),
        .q_levels        (b_levels),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_low     (m_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_data     (m_read_data),
        .m_presence      (m_presence),
        .m_released_high (m_released_high)
    );

endmodule

// ===== tb/tb_onewire_master_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_onewire_master_sequencer_unit;
    import ows_pkg::*;

    // mode codes the block treats as plain ticks
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
    // register index outside the map, writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'hF;
    localparam int LAST_LINE = 2;
    localparam int RANDOM_TICKS = 800;
    localparam int IDLE_PCT = 36;

    // one result transfer, as seen on the m_ side
    typedef struct packed {
        logic [2:0]        drive_low;
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] read_data;
        logic              presence;
        logic              released_high;
    } bus_tick_t;

    typedef enum logic {ROW_WRITE_REG, ROW_COMMAND} row_kind_t;

    // one line of the directed sequence: a register write or a whole command
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [UNIT_W-1:0]       reg_value;
        logic [MODE_W-1:0]       mode;
        logic [SEL_W-1:0]        sel;
        logic [DATA_W-1:0]       wdata;
        logic [2:0]              levels;
        logic                    steady;
        logic                    pinned;
        logic [DATA_W-1:0]       want_read;
        logic                    want_presence;
        logic                    want_high;
    } drill_row_t;

    localparam int DRILL_ROWS = 25;

    // unused fields: reg_index/reg_value on command rows, mode onward on write rows
    // pinned rows carry the done-tick read data, presence and released level
    drill_row_t drill_rows [DRILL_ROWS] = '{
        // plain tick straight after reset shows an idle bus
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_TICK, 2'd0, 8'h00, 3'b111,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        // zero-length short unit behaves as one tick
        '{ROW_WRITE_REG, REG_SHORT_UNIT, 16'h0000, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE_REG, REG_LONG_UNIT, 16'd1, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        // bus reset with a device pulling the line low
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_RESET, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
        // bus reset with nobody answering
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_RESET, 2'd1, 8'h00, 3'b111,
          1'b0, 1'b1, 8'h00, 1'b0, 1'b1},
        // line select past the last line falls back to line 2
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_RESET, 2'd3, 8'h00, 3'b011,
          1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BYTE, 2'd0, 8'hFF, 3'b111,
          1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BYTE, 2'd2, 8'h00, 3'b101,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BYTE, 2'd1, 8'hA5, 3'b010,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_READ_BYTE, 2'd1, 8'h00, 3'b010,
          1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_READ_BYTE, 2'd1, 8'hFF, 3'b101,
          1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BIT, 2'd0, 8'hFE, 3'b110,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BIT, 2'd2, 8'h01, 3'b001,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_READ_BIT, 2'd3, 8'h00, 3'b100,
          1'b0, 1'b1, 8'h01, 1'b1, 1'b0},
        // plain tick and the two undefined modes start nothing
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_TICK, 2'd3, 8'hFF, 3'b111,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_UNDEF_LO, 2'd1, 8'h3C, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_UNDEF_HI, 2'd2, 8'hC3, 3'b111,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        // write to an unmapped index must leave both units alone
        '{ROW_WRITE_REG, REG_UNMAPPED, 16'hFFFF, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE_REG, REG_SHORT_UNIT, 16'd30, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_READ_BIT, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
        '{ROW_WRITE_REG, REG_SHORT_UNIT, 16'd1, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE_REG, REG_LONG_UNIT, 16'd60, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        // long unit, run with no idling on either side
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_WRITE_BIT, 2'd1, 8'h01, 3'b010,
          1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE_REG, REG_LONG_UNIT, 16'h0000, MODE_TICK, 2'd0, 8'h00, 3'b000,
          1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{ROW_COMMAND, REG_SHORT_UNIT, 16'd0, MODE_READ_BYTE, 2'd2, 8'h00, 3'b110,
          1'b0, 1'b1, 8'hFF, 1'b1, 1'b0}
    };

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #6 aclk = ~aclk;

    // block inputs, all known from time zero
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [UNIT_W-1:0]      cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic [MODE_W-1:0]      s_mode = '0;
    logic [SEL_W-1:0]       s_line_select = '0;
    logic [DATA_W-1:0]      s_write_data = '0;
    logic [2:0]             s_line_levels = '0;
    logic                   m_ready = 1'b0;

    // block outputs
    logic              cfg_ready;
    logic              s_ready;
    logic              m_valid;
    logic [2:0]        m_drive_low;
    logic              m_busy_res;
    logic              m_done_res;
    logic [DATA_W-1:0] m_read_data;
    logic              m_presence;
    logic              m_released_high;

    onewire_master_sequencer_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_line_select   (s_line_select),
        .s_write_data    (s_write_data),
        .s_line_levels   (s_line_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_low     (m_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_data     (m_read_data),
        .m_presence      (m_presence),
        .m_released_high (m_released_high)
    );

    // sequencer state as the testbench tracks it
    phase_t            seq_phase;
    logic [UNIT_W-1:0] tick_cnt;
    logic [UCNT_W-1:0] unit_cnt;
    logic [3:0]        bit_cnt;
    logic [DATA_W-1:0] shreg;
    logic [SEL_W-1:0]  act_line;
    logic              one_bit;
    logic              pres_flag;
    logic              high_flag;
    logic [UNIT_W-1:0] short_ticks;
    logic [UNIT_W-1:0] long_ticks;

    // results predicted but not yet seen on the m_ side
    bus_tick_t pending_bus_ticks[$];
    bus_tick_t want_tick;
    int        mismatches = 0;
    int        ticks_sent = 0;

    // idling switches and pinned done-tick values for the current directed row
    logic              src_idle_on = 1'b1;
    logic              sink_idle_on = 1'b1;
    logic              pin_on = 1'b0;
    logic [DATA_W-1:0] pin_read_data;
    logic              pin_presence;
    logic              pin_released_high;

    // advance the sequencer by one tick and return what it shows on the bus
    function automatic bus_tick_t step_sequencer(input logic [MODE_W-1:0] mode,
                                                 input logic [SEL_W-1:0]  sel,
                                                 input logic [DATA_W-1:0] wd,
                                                 input logic [2:0]        lv);
        bus_tick_t         r;
        logic [UCNT_W-1:0] seg_len;
        logic              seg_long;
        logic [16:0]       unit_len;
        logic [16:0]       nxt;
        logic              lvl;
        logic              finished;
        finished = 1'b0;
        r.read_data = '0;
        if (seq_phase == PH_IDLE) begin
            // a command is only taken while idle
            if (mode >= MODE_RESET && mode <= MODE_READ_BIT) begin
                act_line = (sel > SEL_W'(LAST_LINE)) ? SEL_W'(LAST_LINE) : sel;
                tick_cnt = '0;
                unit_cnt = '0;
                bit_cnt = '0;
                one_bit = (mode >= MODE_WRITE_BIT);
                case (mode)
                    MODE_RESET: seq_phase = PH_R1;
                    MODE_WRITE_BYTE: begin
                        shreg = wd;
                        seq_phase = PH_W1;
                    end
                    MODE_READ_BYTE: begin
                        shreg = '0;
                        seq_phase = PH_D1;
                    end
                    MODE_WRITE_BIT: begin
                        shreg = {7'd0, wd[0]};
                        seq_phase = PH_W1;
                    end
                    default: begin
                        shreg = '0;
                        seq_phase = PH_D1;
                    end
                endcase
            end
        end else begin
            // segment length in units and which unit it counts
            case (seq_phase)
                PH_R1: begin seg_len = RST_LOW_UNITS; seg_long = 1'b1; end
                PH_R2: begin seg_len = RST_PRES_UNITS; seg_long = 1'b1; end
                PH_R3: begin seg_len = RST_TAIL_UNITS; seg_long = 1'b1; end
                PH_W1: begin seg_len = WR_LEAD_UNITS; seg_long = 1'b0; end
                PH_W2: begin seg_len = WR_MID_UNITS; seg_long = 1'b1; end
                PH_W3: begin seg_len = WR_TAIL_UNITS; seg_long = 1'b0; end
                PH_D1: begin seg_len = RD_LOW_UNITS; seg_long = 1'b0; end
                PH_D2: begin seg_len = RD_SAMPLE_UNITS; seg_long = 1'b1; end
                PH_D3: begin seg_len = RD_TAIL_UNITS; seg_long = 1'b1; end
                default: begin seg_len = '0; seg_long = 1'b0; end
            endcase
            unit_len = {1'b0, seg_long ? long_ticks : short_ticks};
            nxt = {1'b0, tick_cnt} + 17'd1;
            lvl = lv[act_line];
            // a zero-length unit ends on its first tick
            if (nxt >= unit_len) begin
                tick_cnt = '0;
                unit_cnt = unit_cnt + 1'b1;
                if (unit_cnt >= seg_len) begin
                    unit_cnt = '0;
                    case (seq_phase)
                        PH_R1: seq_phase = PH_R2;
                        PH_R2: begin
                            pres_flag = ~lvl;
                            seq_phase = PH_R3;
                        end
                        PH_R3: begin
                            high_flag = lvl;
                            seq_phase = PH_IDLE;
                            finished = 1'b1;
                        end
                        PH_W1: seq_phase = PH_W2;
                        PH_W2: seq_phase = PH_W3;
                        PH_W3: begin
                            bit_cnt = bit_cnt + 4'd1;
                            if (one_bit || bit_cnt >= 4'd8) begin
                                seq_phase = PH_IDLE;
                                finished = 1'b1;
                            end else begin
                                shreg = shreg >> 1;
                                seq_phase = PH_W1;
                            end
                        end
                        PH_D1: seq_phase = PH_D2;
                        PH_D2: begin
                            // bytes fill from the top, lsb first on the wire
                            shreg = one_bit ? {7'd0, lvl} : {lvl, shreg[7:1]};
                            seq_phase = PH_D3;
                        end
                        default: begin
                            bit_cnt = bit_cnt + 4'd1;
                            if (one_bit || bit_cnt >= 4'd8) begin
                                seq_phase = PH_IDLE;
                                finished = 1'b1;
                                r.read_data = shreg;
                            end else begin
                                seq_phase = PH_D1;
                            end
                        end
                    endcase
                end
            end else begin
                tick_cnt = nxt[UNIT_W-1:0];
            end
        end
        // drive reflects the phase after this tick
        r.drive_low = '0;
        case (seq_phase)
            PH_R1, PH_W1, PH_D1: r.drive_low[act_line] = 1'b1;
            PH_W2: r.drive_low[act_line] = ~shreg[0];
            default: ;
        endcase
        r.busy = (seq_phase != PH_IDLE);
        r.done = finished;
        r.presence = pres_flag;
        r.released_high = high_flag;
        return r;
    endfunction

    // one s_ transfer, with random idle cycles ahead of it
    task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] wd, input logic [2:0] lv);
        int        hold;
        bus_tick_t t;
        hold = 0;
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) hold++;
        if (hold > 0) begin
            s_valid <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_line_select <= sel;
        s_write_data <= wd;
        s_line_levels <= lv;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
        t = step_sequencer(mode, sel, wd, lv);
        // directed rows may fix the done-tick values by hand
        if (t.done && pin_on) begin
            t.read_data = pin_read_data;
            t.presence = pin_presence;
            t.released_high = pin_released_high;
        end
        pending_bus_ticks.push_back(t);
    endtask

    // register write once every result has drained and no command runs
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [UNIT_W-1:0] data,
                             input logic lower);
        s_valid <= 1'b0;
        while (pending_bus_ticks.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SHORT_UNIT: short_ticks = data;
            REG_LONG_UNIT:  long_ticks = data;
            default: ;
        endcase
        if (lower) cfg_valid <= 1'b0;
    endtask

    // random back pressure on the result side
    always @(posedge aclk) begin
        m_ready <= sink_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_bus_ticks.size() == 0) begin
                $error("result transfer with nothing pending");
                mismatches++;
            end else begin
                want_tick = pending_bus_ticks.pop_front();
                if (m_drive_low !== want_tick.drive_low) begin
                    $error("drive_low expected %0h actual %0h", want_tick.drive_low, m_drive_low);
                    mismatches++;
                end
                if (m_busy_res !== want_tick.busy) begin
                    $error("busy_res expected %0b actual %0b", want_tick.busy, m_busy_res);
                    mismatches++;
                end
                if (m_done_res !== want_tick.done) begin
                    $error("done_res expected %0b actual %0b", want_tick.done, m_done_res);
                    mismatches++;
                end
                if (m_read_data !== want_tick.read_data) begin
                    $error("read_data expected %0h actual %0h", want_tick.read_data,
                           m_read_data);
                    mismatches++;
                end
                if (m_presence !== want_tick.presence) begin
                    $error("presence expected %0b actual %0b", want_tick.presence, m_presence);
                    mismatches++;
                end
                if (m_released_high !== want_tick.released_high) begin
                    $error("released_high expected %0b actual %0b", want_tick.released_high,
                           m_released_high);
                    mismatches++;
                end
            end
        end
    end

    // main sequence: reset, directed rows, random commands, drain
    initial begin
        drill_row_t        row;
        logic [MODE_W-1:0] cmd_mode;
        int                stop_at;
        // tracked state starts at its reset values
        seq_phase = PH_IDLE;
        tick_cnt = '0;
        unit_cnt = '0;
        bit_cnt = '0;
        shreg = '0;
        act_line = '0;
        one_bit = 1'b0;
        pres_flag = 1'b0;
        high_flag = 1'b0;
        short_ticks = SHORT_UNIT_RESET;
        long_ticks = LONG_UNIT_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows: each command runs to completion, filler ticks carry
        // random commands that must be ignored while busy
        for (int i = 0; i < DRILL_ROWS; i++) begin
            row = drill_rows[i];
            if (row.kind == ROW_WRITE_REG) begin
                // valid stays up across back-to-back register writes
                write_reg(row.reg_index, row.reg_value,
                          (i + 1 >= DRILL_ROWS) || (drill_rows[i + 1].kind != ROW_WRITE_REG));
            end else begin
                src_idle_on = ~row.steady;
                sink_idle_on = ~row.steady;
                pin_on = row.pinned;
                pin_read_data = row.want_read;
                pin_presence = row.want_presence;
                pin_released_high = row.want_high;
                send_tick(row.mode, row.sel, row.wdata, row.levels);
                while (seq_phase != PH_IDLE) begin
                    send_tick(MODE_W'($urandom_range(7)), SEL_W'($urandom_range(3)),
                              DATA_W'($urandom_range(255)), row.levels);
                end
                pin_on = 1'b0;
                src_idle_on = 1'b1;
                sink_idle_on = 1'b1;
            end
        end

        // random commands with short units, random line levels every tick
        stop_at = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                write_reg(REG_SHORT_UNIT,
                          UNIT_W'(($urandom_range(9) == 0) ? $urandom_range(5, 40)
                                                           : $urandom_range(0, 3)),
                          1'b0);
                write_reg(REG_LONG_UNIT,
                          UNIT_W'(($urandom_range(9) == 0) ? $urandom_range(5, 40)
                                                           : $urandom_range(0, 3)),
                          1'b1);
            end
            // mostly real commands, some plain and undefined modes as noise
            cmd_mode = MODE_W'(($urandom_range(4) == 0) ? $urandom_range(7)
                                                        : $urandom_range(1, 5));
            send_tick(cmd_mode, SEL_W'($urandom_range(3)), DATA_W'($urandom_range(255)),
                      3'($urandom_range(7)));
            while (seq_phase != PH_IDLE) begin
                send_tick(MODE_W'($urandom_range(7)), SEL_W'($urandom_range(3)),
                          DATA_W'($urandom_range(255)), 3'($urandom_range(7)));
            end
        end

        // drain, then wait for anything stray
        s_valid <= 1'b0;
        while (pending_bus_ticks.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, well beyond the longest unit run
    initial begin
        #(40_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ows_pkg.sv
rtl/ows_front.sv
rtl/ows_fifo.sv
rtl/ows_back.sv
rtl/onewire_master_sequencer_unit.sv
tb/tb_onewire_master_sequencer_unit.sv
